### src/dema_pkg.sv
// ----------------------------------------------------------------------------
// dema_pkg
// Shared types and constants for the dual average trend detector.
// ----------------------------------------------------------------------------
package dema_pkg;

    // channel and data geometry
    localparam int NUM_CHANNELS = 5;
    localparam int CH_W         = 3;
    localparam int DATA_W       = 32;
    localparam int THRESH_W     = 31;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_BASE = 3'd2;

    // averaging spans used for the reset weights
    localparam int FAST_SAMPLES = 4;
    localparam int SLOW_SAMPLES = 32;

    // trend codes
    typedef enum logic [1:0] {
        TREND_STEADY  = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2
    } trend_t;

endpackage

### src/dual_ema_trend_detector_top.sv
// ----------------------------------------------------------------------------
// dual_ema_trend_detector_top
// Five-channel fast/slow exponential average trend detector.
// ----------------------------------------------------------------------------
// Takes one signed fixed-point sample per transfer with a channel 0..4 and
// returns the channel, a trend code (steady, rising, falling) and both updated
// averages. Zero samples and channels above 4 are taken and dropped with no
// result. One sample is accepted every cycle while the result side takes its
// results. A result passes the input register, then the result register, and
// is held there until taken. The rate is set by the single update path
// between them: one multiply per average, the add and the fast-minus-slow
// compare. The per-channel averages are written as an item moves into the
// result register, so back-to-back samples on the same channel see each
// other's update. Configuration is written through a plain write port; the
// user must write it while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_ema_trend_detector_top
    import dema_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = 16,
    parameter int ALPHA_FRAC_BITS  = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // sample input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CH_W-1:0]          s_channel,
    input  logic signed [DATA_W-1:0] s_sample,
    // trend result
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CH_W-1:0]          m_result_channel,
    output logic [1:0]               m_trend,
    output logic signed [DATA_W-1:0] m_fast_average,
    output logic signed [DATA_W-1:0] m_slow_average,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
    localparam longint ALPHA_ONE = longint'(1) << ALPHA_FRAC_BITS;
    localparam longint SAMPLE_ONE = longint'(1) << SAMPLE_FRAC_BITS;
    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST =
        ALPHA_W'((ALPHA_ONE * 2) / (FAST_SAMPLES + 1));
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST =
        ALPHA_W'((ALPHA_ONE * 2) / (SLOW_SAMPLES + 1));
    localparam logic [THRESH_W-1:0] THRESH_HALF = THRESH_W'(SAMPLE_ONE / 2);
    localparam logic [THRESH_W-1:0] THRESH_HUNDREDTH = THRESH_W'((SAMPLE_ONE + 50) / 100);

    // input stage
    logic                     in_valid_reg;
    logic [CH_W-1:0]          in_channel_reg;
    logic signed [DATA_W-1:0] in_sample_reg;

    // result stage
    logic                     m_valid_reg;
    logic [CH_W-1:0]          m_channel_reg;
    trend_t                   m_trend_reg;
    logic signed [DATA_W-1:0] m_fast_reg;
    logic signed [DATA_W-1:0] m_slow_reg;

    // per-channel averages, zero means unseeded
    logic signed [DATA_W-1:0] fast_store_reg [NUM_CHANNELS];
    logic signed [DATA_W-1:0] slow_store_reg [NUM_CHANNELS];

    logic                     advance;
    logic                     in_take;
    logic                     in_valid_next;
    logic [ALPHA_W-1:0]       fast_alpha;
    logic [ALPHA_W-1:0]       slow_alpha;
    logic [THRESH_W-1:0]      threshold;
    logic signed [DATA_W-1:0] fast_new;
    logic signed [DATA_W-1:0] slow_new;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W:0]   thr_pos;
    logic signed [DATA_W:0]   thr_neg;
    trend_t                   trend_next;

    // configuration registers
    dema_cfg #(
        .ALPHA_W         (ALPHA_W),
        .FAST_ALPHA_RST  (FAST_ALPHA_RST),
        .SLOW_ALPHA_RST  (SLOW_ALPHA_RST),
        .THRESH_RST      (THRESH_HALF),
        .THRESH_LAST_RST (THRESH_HUNDREDTH)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .rd_channel  (in_channel_reg),
        .fast_alpha  (fast_alpha),
        .slow_alpha  (slow_alpha),
        .threshold   (threshold)
    );

    // fast and slow average updates
    dema_ema #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_fast (
        .avg     (fast_store_reg[in_channel_reg]),
        .sample  (in_sample_reg),
        .alpha   (fast_alpha),
        .avg_new (fast_new)
    );

    dema_ema #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_slow (
        .avg     (slow_store_reg[in_channel_reg]),
        .sample  (in_sample_reg),
        .alpha   (slow_alpha),
        .avg_new (slow_new)
    );

    // handshake: input stage moves on when the result register is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !m_valid_reg || m_ready;
    assign in_take = s_valid && s_ready;

    // drop empty samples and unknown channels at the door
    always_comb begin
        in_valid_next = in_valid_reg && !advance;
        if (in_take) begin
            in_valid_next = (s_sample != '0) && (s_channel < CH_W'(NUM_CHANNELS));
        end
    end

    // trend decision against the channel dead band
    always_comb begin
        diff    = {fast_new[DATA_W-1], fast_new} - {slow_new[DATA_W-1], slow_new};
        thr_pos = $signed({2'b00, threshold});
        thr_neg = -thr_pos;
        if (diff > thr_pos) begin
            trend_next = TREND_RISING;
        end else if (diff < thr_neg) begin
            trend_next = TREND_FALLING;
        end else begin
            trend_next = TREND_STEADY;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_take) begin
            in_channel_reg <= s_channel;
            in_sample_reg  <= s_sample;
        end
    end

    // result register and average state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                fast_store_reg[i] <= '0;
                slow_store_reg[i] <= '0;
            end
        end else begin
            if (advance) begin
                m_valid_reg                    <= 1'b1;
                fast_store_reg[in_channel_reg] <= fast_new;
                slow_store_reg[in_channel_reg] <= slow_new;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            m_channel_reg <= in_channel_reg;
            m_trend_reg   <= trend_next;
            m_fast_reg    <= fast_new;
            m_slow_reg    <= slow_new;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_channel = m_channel_reg;
    assign m_trend          = m_trend_reg;
    assign m_fast_average   = m_fast_reg;
    assign m_slow_average   = m_slow_reg;

`ifndef SYNTH
    // a zero sample never reaches the compute stage
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_sample == '0)) |=> !in_valid_reg)
        else $error("zero sample entered the compute stage");

    // reported channel is always a real channel
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_channel < CH_W'(NUM_CHANNELS)))
        else $error("result for a channel out of range");

    // rising means the fast average sits above the slow one
    a_rising_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_trend == TREND_RISING)) |-> (m_fast_average > m_slow_average))
        else $error("rising trend with fast not above slow");

    // falling means the fast average sits below the slow one
    a_falling_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_trend == TREND_FALLING)) |-> (m_fast_average < m_slow_average))
        else $error("falling trend with fast not below slow");
`endif

endmodule

### src/dema_cfg.sv
// ----------------------------------------------------------------------------
// dema_cfg
// Configuration registers: two averaging weights and one dead band per channel.
// ----------------------------------------------------------------------------
module dema_cfg
    import dema_pkg::*;
#(
    parameter int                        ALPHA_W        = 17,
    parameter logic [ALPHA_W-1:0]        FAST_ALPHA_RST = '0,
    parameter logic [ALPHA_W-1:0]        SLOW_ALPHA_RST = '0,
    parameter logic [THRESH_W-1:0]       THRESH_RST     = '0,
    parameter logic [THRESH_W-1:0]       THRESH_LAST_RST = '0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [CH_W-1:0]       rd_channel,
    output logic [ALPHA_W-1:0]    fast_alpha,
    output logic [ALPHA_W-1:0]    slow_alpha,
    output logic [THRESH_W-1:0]   threshold
);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << (ALPHA_W - 1);

    logic [ALPHA_W-1:0]  fast_alpha_reg;
    logic [ALPHA_W-1:0]  slow_alpha_reg;
    logic [THRESH_W-1:0] thresh_reg [NUM_CHANNELS];

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_alpha_reg <= FAST_ALPHA_RST;
            slow_alpha_reg <= SLOW_ALPHA_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                thresh_reg[i] <= (i == NUM_CHANNELS - 1) ? THRESH_LAST_RST : THRESH_RST;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_FAST_ALPHA) begin
                fast_alpha_reg <= cfg_wr_data[ALPHA_W-1:0];
            end
            if (cfg_index == CFG_SLOW_ALPHA) begin
                slow_alpha_reg <= cfg_wr_data[ALPHA_W-1:0];
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (cfg_index == CFG_THRESH_BASE + CFG_IDX_W'(i)) begin
                    thresh_reg[i] <= cfg_wr_data[THRESH_W-1:0];
                end
            end
        end
    end

    // weights above one count as exactly one
    assign fast_alpha = (fast_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : fast_alpha_reg;
    assign slow_alpha = (slow_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : slow_alpha_reg;

    // dead band of the channel in the compute stage
    assign threshold = thresh_reg[rd_channel];

endmodule

### src/dema_ema.sv
// ----------------------------------------------------------------------------
// dema_ema
// One exponential average update with seeding of an empty average.
// ----------------------------------------------------------------------------
module dema_ema
    import dema_pkg::*;
#(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic signed [DATA_W-1:0]        avg,
    input  logic signed [DATA_W-1:0]        sample,
    input  logic        [ALPHA_FRAC_BITS:0] alpha,
    output logic signed [DATA_W-1:0]        avg_new
);

    localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
    localparam int PROD_W  = DATA_W + 1 + ALPHA_W + 1;

    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W:0]   delta;
    logic signed [PROD_W-1:0] delta_ext;
    logic signed [PROD_W-1:0] alpha_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;

    // avg*(1-a) + s*a rewritten as avg + (s-avg)*a, floor via arithmetic shift
    always_comb begin
        base      = (avg == '0) ? sample : avg;
        delta     = {sample[DATA_W-1], sample} - {base[DATA_W-1], base};
        delta_ext = PROD_W'(delta);
        alpha_ext = $signed({{(PROD_W-ALPHA_W){1'b0}}, alpha});
        prod      = delta_ext * alpha_ext;
        step      = prod >>> ALPHA_FRAC_BITS;
        avg_new   = base + step[DATA_W-1:0];
    end

endmodule

### tb/dual_ema_trend_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_ema_trend_detector_top_tb
// Self-checking bench for the five-channel fast/slow average trend detector.
// ----------------------------------------------------------------------------
// Samples go in over a valid/ready channel with random gaps. An in-bench
// predictor keeps its own copy of the weights, dead bands and per-channel
// averages and queues the result that each accepted sample should produce.
// Every result transfer is checked field by field against the oldest queued
// result. Directed tests cover reset weights, dropped samples, full-scale
// values with extreme weights and the decay-to-zero reseed. The random part
// runs several weight and dead band settings with drifting per-channel signals.
// ----------------------------------------------------------------------------
module dual_ema_trend_detector_top_tb;
    import dema_pkg::*;

    localparam int SAMPLE_FRAC    = 16;
    localparam int ALPHA_FRAC     = 16;
    localparam int ALPHA_W        = ALPHA_FRAC + 1;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int IDLE_LIMIT     = 4000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 6;
    localparam int ITEMS_PER_PHASE = 195;

    localparam longint WEIGHT_ONE_L = longint'(1) << ALPHA_FRAC;

    // register values used by the tests
    localparam logic [CFG_DATA_W-1:0] WEIGHT_ONE  = CFG_DATA_W'(WEIGHT_ONE_L);
    localparam logic [CFG_DATA_W-1:0] WEIGHT_HALF = WEIGHT_ONE >> 1;
    localparam logic [CFG_DATA_W-1:0] WEIGHT_OVER = CFG_DATA_W'((1 << ALPHA_W) - 1);
    localparam logic [CFG_DATA_W-1:0] WEIGHT_FAST_RST =
        CFG_DATA_W'((2 * WEIGHT_ONE_L) / (FAST_SAMPLES + 1));
    localparam logic [CFG_DATA_W-1:0] WEIGHT_SLOW_RST =
        CFG_DATA_W'((2 * WEIGHT_ONE_L) / (SLOW_SAMPLES + 1));
    localparam logic [CFG_DATA_W-1:0] BAND_HALF      = CFG_DATA_W'(1 << (SAMPLE_FRAC - 1));
    localparam logic [CFG_DATA_W-1:0] BAND_HUNDREDTH =
        CFG_DATA_W'(((1 << SAMPLE_FRAC) + 50) / 100);
    localparam logic [CFG_DATA_W-1:0] BAND_MAX = {CFG_DATA_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0]  REG_UNUSED = CFG_IDX_W'(CFG_THRESH_BASE + NUM_CHANNELS);

    // sample values
    localparam logic [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] UNIT       = DATA_W'(1 << SAMPLE_FRAC);

    typedef struct {
        logic [CH_W-1:0]          channel;
        trend_t                   trend;
        logic signed [DATA_W-1:0] fast_avg;
        logic signed [DATA_W-1:0] slow_avg;
    } trend_result_t;

    // dut signals
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [CH_W-1:0]          s_channel = '0;
    logic signed [DATA_W-1:0] s_sample  = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [CH_W-1:0]          m_result_channel;
    logic [1:0]               m_trend;
    logic signed [DATA_W-1:0] m_fast_average;
    logic signed [DATA_W-1:0] m_slow_average;
    logic                     cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]    cfg_wr_data = '0;

    // predictor state: register copies and per-channel averages
    logic [ALPHA_W-1:0]    fast_weight;
    logic [ALPHA_W-1:0]    slow_weight;
    logic [THRESH_W-1:0]   dead_band [NUM_CHANNELS];
    longint                fast_level [NUM_CHANNELS];
    longint                slow_level [NUM_CHANNELS];
    logic [CFG_DATA_W-1:0] band_plan [NUM_CHANNELS];

    trend_result_t pending_trends[$];
    int            error_count = 0;
    logic          idling_on   = 1'b1;
    int            ready_hold  = 0;

    dual_ema_trend_detector_top #(
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC),
        .ALPHA_FRAC_BITS  (ALPHA_FRAC)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_channel (m_result_channel),
        .m_trend          (m_trend),
        .m_fast_average   (m_fast_average),
        .m_slow_average   (m_slow_average),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    // clock
    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int idle_len();
        int pick;
        if (!idling_on) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // one average step: seed when unseeded, weight clamped at one, floor shift
    function automatic longint ema_next(input longint avg, input longint smp,
                                        input logic [ALPHA_W-1:0] weight);
        longint w;
        w = longint'(weight);
        if (w > WEIGHT_ONE_L) begin
            w = WEIGHT_ONE_L;
        end
        if (avg == 0) begin
            avg = smp;
        end
        return (avg * (WEIGHT_ONE_L - w) + smp * w) >>> ALPHA_FRAC;
    endfunction

    // updates the channel averages and queues the trend that should come out
    task automatic predict_trend(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] smp);
        longint        f;
        longint        s;
        longint        diff;
        longint        band;
        trend_result_t rec;
        if (ch >= NUM_CHANNELS || smp == '0) begin
            return;
        end
        f = ema_next(fast_level[ch], longint'($signed(smp)), fast_weight);
        s = ema_next(slow_level[ch], longint'($signed(smp)), slow_weight);
        fast_level[ch] = f;
        slow_level[ch] = s;
        diff = f - s;
        band = longint'(dead_band[ch]);
        if (diff > band) begin
            rec.trend = TREND_RISING;
        end else if (diff < -band) begin
            rec.trend = TREND_FALLING;
        end else begin
            rec.trend = TREND_STEADY;
        end
        rec.channel  = ch;
        rec.fast_avg = f[DATA_W-1:0];
        rec.slow_avg = s[DATA_W-1:0];
        pending_trends.push_back(rec);
    endtask

    task automatic predictor_reset();
        fast_weight = WEIGHT_FAST_RST[ALPHA_W-1:0];
        slow_weight = WEIGHT_SLOW_RST[ALPHA_W-1:0];
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            dead_band[k]  = BAND_HALF[THRESH_W-1:0];
            fast_level[k] = 0;
            slow_level[k] = 0;
        end
        dead_band[NUM_CHANNELS-1] = BAND_HUNDREDTH[THRESH_W-1:0];
    endtask

    // send one sample; valid stays high after the transfer until the next call
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] smp);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_trend(ch, smp);
    endtask

    // stop sending and let every queued result come out
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_trends.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write; enable is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_FAST_ALPHA: fast_weight = val[ALPHA_W-1:0];
            CFG_SLOW_ALPHA: slow_weight = val[ALPHA_W-1:0];
            default: begin
                if (idx >= CFG_THRESH_BASE && idx < CFG_THRESH_BASE + NUM_CHANNELS) begin
                    dead_band[idx - CFG_THRESH_BASE] = val[THRESH_W-1:0];
                end
            end
        endcase
    endtask

    // full register set from idle, plus a write to the unused index
    task automatic configure(input logic [CFG_DATA_W-1:0] fast_w,
                             input logic [CFG_DATA_W-1:0] slow_w);
        wait_idle();
        write_reg(CFG_FAST_ALPHA, fast_w);
        write_reg(CFG_SLOW_ALPHA, slow_w);
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            write_reg(CFG_IDX_W'(CFG_THRESH_BASE + k), band_plan[k]);
        end
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_bands(input logic [CFG_DATA_W-1:0] band);
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            band_plan[k] = band;
        end
    endtask

    // reset weights and dead bands, no register writes yet
    task automatic test_reset_defaults();
        send_sample(3'd0, UNIT);
        send_sample(3'd4, 2 * UNIT);
        send_sample(3'd1, -(7 * UNIT / 2));
        send_sample(3'd2, UNIT);
        send_sample(3'd2, 16 * UNIT);
        send_sample(3'd3, 16 * UNIT);
        send_sample(3'd3, UNIT);
    endtask

    // zero samples and out-of-range channels are dropped without a result
    task automatic test_dropped_samples();
        send_sample(3'd0, '0);
        send_sample(3'd5, 32'h1234_5678);
        send_sample(3'd6, SAMPLE_MIN);
        send_sample(3'd7, '1);
        send_sample(3'd7, '0);
        send_sample(3'd0, 2 * UNIT);
    endtask

    // full-scale samples against the widest dead band, weights at the ends
    task automatic test_full_scale();
        set_bands(BAND_MAX);
        configure(WEIGHT_ONE, WEIGHT_ONE);
        send_sample(3'd0, SAMPLE_MIN);
        send_sample(3'd1, SAMPLE_MAX);
        // weight above one acts as one, zero weight freezes the slow average
        configure(WEIGHT_OVER, '0);
        send_sample(3'd0, SAMPLE_MAX);
        send_sample(3'd1, SAMPLE_MIN);
        set_bands('0);
        configure('0, WEIGHT_ONE);
        send_sample(3'd2, 3 * UNIT);
        send_sample(3'd2, -UNIT);
    endtask

    // an average that reaches zero is reseeded; negative results floor down
    task automatic test_decay_reseed();
        set_bands('0);
        configure(WEIGHT_ONE, WEIGHT_ONE);
        send_sample(3'd3, 1);
        send_sample(3'd4, -3);
        configure(WEIGHT_HALF, WEIGHT_HALF);
        send_sample(3'd3, -1);
        send_sample(3'd3, 5 * UNIT);
        send_sample(3'd4, 2);
    endtask

    // several settings, drifting signals per channel mixed with noise
    task automatic test_random_traffic();
        int                    live;
        int                    pick;
        int                    level [NUM_CHANNELS];
        int                    stride [NUM_CHANNELS];
        logic [CH_W-1:0]       ch;
        logic [DATA_W-1:0]     smp;
        logic [CFG_DATA_W-1:0] fast_w;
        logic [CFG_DATA_W-1:0] slow_w;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            level[k]  = $urandom_range(0, 100 << SAMPLE_FRAC) - (50 << SAMPLE_FRAC);
            stride[k] = $urandom_range(0, 2 << SAMPLE_FRAC) - (1 << SAMPLE_FRAC);
        end
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    fast_w = WEIGHT_FAST_RST;
                    slow_w = WEIGHT_SLOW_RST;
                    set_bands(BAND_HALF);
                    band_plan[NUM_CHANNELS-1] = BAND_HUNDREDTH;
                end
                1: begin
                    fast_w = '0;
                    slow_w = '0;
                    set_bands('0);
                end
                2: begin
                    fast_w = WEIGHT_ONE;
                    slow_w = WEIGHT_OVER;
                    set_bands(BAND_MAX);
                end
                default: begin
                    fast_w = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(65537, 131071)
                                         : $urandom_range(0, 65536));
                    slow_w = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(65537, 131071)
                                         : $urandom_range(0, 8192));
                    // bits above the weight field are ignored
                    if ($urandom_range(0, 1)) begin
                        fast_w[CFG_DATA_W-1:ALPHA_W] = (CFG_DATA_W-ALPHA_W)'($urandom);
                    end
                    if ($urandom_range(0, 1)) begin
                        slow_w[CFG_DATA_W-1:ALPHA_W] = (CFG_DATA_W-ALPHA_W)'($urandom);
                    end
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        case ($urandom_range(0, 4))
                            0: band_plan[k] = '0;
                            1: band_plan[k] = CFG_DATA_W'($urandom_range(0, 1 << SAMPLE_FRAC));
                            2: band_plan[k] = CFG_DATA_W'($urandom_range(0, 1 << 20));
                            3: band_plan[k] = CFG_DATA_W'($urandom_range(0, 1 << 18));
                            default: band_plan[k] = CFG_DATA_W'($urandom);
                        endcase
                    end
                end
            endcase
            configure(fast_w, slow_w);
            live = 0;
            while (live < ITEMS_PER_PHASE) begin
                // alternate stretches with and without idling
                if ($urandom_range(0, 59) == 0) idling_on <= ~idling_on;
                ch = CH_W'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, NUM_CHANNELS - 1));
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    smp = '0;
                end else if (pick < 20) begin
                    smp = $urandom_range(0, 16) - 8;
                end else if (pick < 38) begin
                    smp = $urandom;
                end else if (pick < 44) begin
                    case ($urandom_range(0, 3))
                        0:       smp = SAMPLE_MIN;
                        1:       smp = SAMPLE_MAX;
                        2:       smp = 1;
                        default: smp = '1;
                    endcase
                end else if (ch < NUM_CHANNELS) begin
                    if ($urandom_range(0, 24) == 0) begin
                        stride[ch] = $urandom_range(0, 8 << SAMPLE_FRAC) - (4 << SAMPLE_FRAC);
                    end
                    level[ch] = level[ch] + stride[ch];
                    if (level[ch] > (1 << 30) || level[ch] < -(1 << 30)) begin
                        level[ch] = 0;
                    end
                    smp = level[ch] + $urandom_range(0, 2 << SAMPLE_FRAC) - (1 << SAMPLE_FRAC);
                end else begin
                    smp = $urandom;
                end
                send_sample(ch, smp);
                if (ch < NUM_CHANNELS && smp != '0) live++;
            end
        end
    endtask

    // result side ready pacing
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= idling_on ? ($urandom_range(0, 2) != 0) : 1'b1;
            ready_hold <= idle_len();
        end
    end

    // compare each result transfer with the oldest queued trend
    always @(posedge aclk) begin : result_check
        trend_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_trends.size() == 0) begin
                report_error($sformatf("result with none queued: channel %0d trend %0d",
                                       m_result_channel, m_trend));
            end else begin
                want = pending_trends.pop_front();
                if (m_result_channel !== want.channel)
                    report_error($sformatf("channel got %0d want %0d",
                                           m_result_channel, want.channel));
                if (m_trend !== want.trend)
                    report_error($sformatf("ch %0d trend got %0d want %0d",
                                           want.channel, m_trend, want.trend));
                if (m_fast_average !== want.fast_avg)
                    report_error($sformatf("ch %0d fast average got %0d want %0d",
                                           want.channel, m_fast_average, want.fast_avg));
                if (m_slow_average !== want.slow_avg)
                    report_error($sformatf("ch %0d slow average got %0d want %0d",
                                           want.channel, m_slow_average, want.slow_avg));
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("dual_ema_trend_detector_top_tb: done, errors");
        $finish;
    end

    // test sequence
    initial begin
        predictor_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_dropped_samples();
        test_full_scale();
        test_decay_reseed();
        test_random_traffic();
        wait_idle();
        if (pending_trends.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_trends.size()));
        end
        if (error_count == 0) begin
            $display("dual_ema_trend_detector_top_tb: done, clean");
        end else begin
            $display("dual_ema_trend_detector_top_tb: done, errors");
        end
        $finish;
    end

endmodule
